FILE: src/plob_pkg.sv
package plob_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_SHIFT,
      ST_PLACE,
      ST_MATCH,
      ST_SUM
   } state_type;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

endpackage

FILE: src/plob_ram.sv
module plob_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/price_level_order_book_matcher.sv
// Price-level order book matcher. Both sides live in one synchronous RAM as
// rings of sorted levels (bids highest first, asks lowest first); removing
// the best level only moves a head pointer. An item is taken when start is
// high and busy is low; busy drops in the cycle in which the item's summary
// is on the result ports. Results appear one per cycle on rsp_valid and
// must be taken as they come: the receiver cannot stall the block.
// An add reads one level at a time while scanning (the scan stops at the
// level that holds or follows its price), then shifts any levels that follow
// to open a slot and writes a new level (the single write port moves one
// level per cycle). A match trades level after level, and a limit price can
// stop it; each trade is one RAM read at the ring head.
// Every item ends with a summary result flagged rsp_last.
module price_level_order_book_matcher #(
   parameter int LEVELS     = 32,
   parameter int PRICE_BITS = 24,
   parameter int QTY_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic        req_side_is_bid,
   input  logic        req_is_limit,
   input  logic [23:0] req_price_cents,
   input  logic [31:0] req_quantity,
   input  logic [31:0] req_order_ident,
   input  logic [47:0] req_time_stamp,
   output logic        rsp_valid,
   output logic        rsp_is_summary,
   output logic [23:0] rsp_trade_price_cents,
   output logic [31:0] rsp_trade_quantity,
   output logic [31:0] rsp_taker_ident,
   output logic [47:0] rsp_trade_time,
   output logic [31:0] rsp_total_traded,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int IW = $clog2(LEVELS);
   localparam int CW = $clog2(LEVELS + 1);
   localparam int MW = (QTY_BITS > 32) ? QTY_BITS : 32;
   localparam int DW = PRICE_BITS + QTY_BITS;
   localparam int AW = IW + 1;
   localparam logic [CW-1:0] LV_C = CW'(LEVELS);
   localparam logic [QTY_BITS-1:0] QMAX = {QTY_BITS{1'b1}};

   function automatic logic [IW-1:0] phys_idx(input logic [IW-1:0] h,
                                              input logic [CW-1:0] l);
      logic [CW:0] s;
      s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, l};
      if (s >= {1'b0, LV_C}) begin
         s = s - {1'b0, LV_C};
      end
      return s[IW-1:0];
   endfunction

   plob_pkg::state_type state_ff, state_in;

   logic [CW-1:0] bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   logic [IW-1:0] bid_head_ff, bid_head_in, ask_head_ff, ask_head_in;

   logic                  op_ff, op_in;
   logic                  tbl_ff, tbl_in;
   logic                  limit_ff, limit_in;
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [QTY_BITS-1:0]   qty_ff, qty_in;
   logic [MW-1:0]         rem_ff, rem_in;
   logic [31:0]           total_ff, total_in;
   logic [31:0]           ident_ff, ident_in;
   logic [47:0]           ts_ff, ts_in;
   logic [1:0]            st_ff, st_in;
   logic [CW-1:0]         i_ff, i_in, j_ff, j_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_summ_ff, rsp_summ_in;
   logic [23:0] rsp_price_ff, rsp_price_in;
   logic [31:0] rsp_qty_ff, rsp_qty_in;
   logic [31:0] rsp_total_ff, rsp_total_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic          tbl_sel;
   logic [CW-1:0] cur_cnt;
   logic [IW-1:0] cur_head;
   logic [CW-1:0] rd_log;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [DW-1:0] rd_data;

   logic [PRICE_BITS-1:0]    lp;
   logic [QTY_BITS-1:0]      lq;
   logic [PRICE_BITS+23:0]   pwide_req, pwide_out, pwide_lvl;
   logic [QTY_BITS+31:0]     qwide;
   logic                     qsat;
   logic [MW+31:0]           rwide;
   logic [MW+QTY_BITS-1:0]   lqwide;
   logic [MW-1:0]            lq_m, vol, newq_m, rem_left;
   logic [QTY_BITS:0]        merge_sum;
   logic                     bid_tbl_better;
   logic                     limit_stop;

   plob_ram #(
      .WIDTH(DW),
      .DEPTH(2 * (1 << IW))
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign pwide_req = {{PRICE_BITS{1'b0}}, req_price_cents};
   assign pwide_out = {24'b0, price_ff};
   assign qwide     = {{QTY_BITS{1'b0}}, req_quantity};
   assign qsat      = |qwide[QTY_BITS+31:QTY_BITS];
   assign rwide     = {{MW{1'b0}}, req_quantity};

   assign lp        = rd_data[DW-1:QTY_BITS];
   assign lq        = rd_data[QTY_BITS-1:0];
   assign pwide_lvl = {24'b0, lp};
   assign lqwide    = {{MW{1'b0}}, lq};
   assign lq_m      = lqwide[MW-1:0];
   assign vol       = (rem_ff < lq_m) ? rem_ff : lq_m;
   assign newq_m    = lq_m - vol;
   assign rem_left  = rem_ff - vol;
   assign merge_sum = {1'b0, lq} + {1'b0, qty_ff};
   // level lies past the new price in its side's order
   assign bid_tbl_better = tbl_ff ? (lp < price_ff) : (lp > price_ff);
   // table ask means the taker buys
   assign limit_stop = limit_ff && (tbl_ff ? (price_ff > lp) : (price_ff < lp));

   assign tbl_sel  = (state_ff == plob_pkg::ST_IDLE) ?
                     ((req_operation == plob_pkg::OP_MATCH) ? !req_side_is_bid
                                                            : req_side_is_bid)
                     : tbl_ff;
   assign cur_cnt  = tbl_sel ? bid_cnt_ff : ask_cnt_ff;
   assign cur_head = tbl_sel ? bid_head_ff : ask_head_ff;
   assign rd_addr  = {tbl_sel, phys_idx(cur_head, rd_log)};

   always_comb begin
      state_in      = state_ff;
      bid_cnt_in    = bid_cnt_ff;
      ask_cnt_in    = ask_cnt_ff;
      bid_head_in   = bid_head_ff;
      ask_head_in   = ask_head_ff;
      op_in         = op_ff;
      tbl_in        = tbl_ff;
      limit_in      = limit_ff;
      price_in      = price_ff;
      qty_in        = qty_ff;
      rem_in        = rem_ff;
      total_in      = total_ff;
      ident_in      = ident_ff;
      ts_in         = ts_ff;
      st_in         = st_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rd_log        = '0;
      wr_en         = 1'b0;
      wr_addr       = {tbl_ff, phys_idx(cur_head, i_ff)};
      wr_data       = {price_ff, qty_ff};
      rsp_valid_in  = 1'b0;
      rsp_summ_in   = rsp_summ_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         plob_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               tbl_in   = tbl_sel;
               limit_in = req_is_limit;
               price_in = pwide_req[PRICE_BITS-1:0];
               qty_in   = qsat ? QMAX : qwide[QTY_BITS-1:0];
               rem_in   = rwide[MW-1:0];
               total_in = '0;
               ident_in = req_order_ident;
               ts_in    = req_time_stamp;
               st_in    = plob_pkg::STATUS_OK;
               i_in     = '0;
               if (req_quantity == '0) begin
                  state_in = plob_pkg::ST_SUM;
               end else if (req_operation == plob_pkg::OP_ADD) begin
                  st_in = qsat ? plob_pkg::STATUS_SAT : plob_pkg::STATUS_OK;
                  state_in = (cur_cnt == '0) ? plob_pkg::ST_PLACE
                                             : plob_pkg::ST_ADD_SCAN;
               end else begin
                  state_in = (cur_cnt == '0) ? plob_pkg::ST_SUM
                                             : plob_pkg::ST_MATCH;
               end
            end
         end
         plob_pkg::ST_ADD_SCAN: begin
            if (lp == price_ff) begin
               wr_en   = 1'b1;
               wr_data = {lp, merge_sum[QTY_BITS] ? QMAX : merge_sum[QTY_BITS-1:0]};
               if (merge_sum[QTY_BITS]) begin
                  st_in = plob_pkg::STATUS_SAT;
               end
               state_in = plob_pkg::ST_SUM;
            end else if (bid_tbl_better) begin
               if (cur_cnt >= LV_C) begin
                  st_in    = plob_pkg::STATUS_FULL;
                  state_in = plob_pkg::ST_SUM;
               end else begin
                  j_in     = cur_cnt;
                  rd_log   = cur_cnt - 1'b1;
                  state_in = plob_pkg::ST_SHIFT;
               end
            end else begin
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 == cur_cnt) begin
                  if (cur_cnt >= LV_C) begin
                     st_in    = plob_pkg::STATUS_FULL;
                     state_in = plob_pkg::ST_SUM;
                  end else begin
                     state_in = plob_pkg::ST_PLACE;
                  end
               end else begin
                  rd_log = i_ff + 1'b1;
               end
            end
         end
         plob_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = {tbl_ff, phys_idx(cur_head, j_ff)};
            wr_data = rd_data;
            j_in    = j_ff - 1'b1;
            rd_log  = j_ff - 2'd2;
            if (j_ff - 1'b1 == i_ff) begin
               state_in = plob_pkg::ST_PLACE;
            end
         end
         plob_pkg::ST_PLACE: begin
            wr_en = 1'b1;
            if (tbl_ff) begin
               bid_cnt_in = bid_cnt_ff + 1'b1;
            end else begin
               ask_cnt_in = ask_cnt_ff + 1'b1;
            end
            state_in = plob_pkg::ST_SUM;
         end
         plob_pkg::ST_MATCH: begin
            if (limit_stop) begin
               state_in = plob_pkg::ST_SUM;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_summ_in   = 1'b0;
               rsp_price_in  = pwide_lvl[23:0];
               rsp_qty_in    = vol[31:0];
               rsp_total_in  = '0;
               rsp_status_in = plob_pkg::STATUS_OK;
               rem_in        = rem_left;
               total_in      = total_ff + vol[31:0];
               if (newq_m == '0) begin
                  if (tbl_ff) begin
                     bid_head_in = phys_idx(bid_head_ff, CW'(1));
                     bid_cnt_in  = bid_cnt_ff - 1'b1;
                  end else begin
                     ask_head_in = phys_idx(ask_head_ff, CW'(1));
                     ask_cnt_in  = ask_cnt_ff - 1'b1;
                  end
                  rd_log = CW'(1);
                  if (rem_left == '0 || cur_cnt == CW'(1)) begin
                     state_in = plob_pkg::ST_SUM;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = {tbl_ff, cur_head};
                  wr_data  = {lp, newq_m[QTY_BITS-1:0]};
                  state_in = plob_pkg::ST_SUM;
               end
            end
         end
         plob_pkg::ST_SUM: begin
            rsp_valid_in  = 1'b1;
            rsp_summ_in   = 1'b1;
            rsp_qty_in    = '0;
            rsp_status_in = st_ff;
            if (op_ff == plob_pkg::OP_ADD) begin
               rsp_price_in = pwide_out[23:0];
               rsp_total_in = '0;
            end else begin
               rsp_price_in = '0;
               rsp_total_in = total_ff;
            end
            state_in = plob_pkg::ST_IDLE;
         end
         default: begin
            state_in = plob_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plob_pkg::ST_IDLE;
         bid_cnt_ff   <= '0;
         ask_cnt_ff   <= '0;
         bid_head_ff  <= '0;
         ask_head_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bid_cnt_ff   <= bid_cnt_in;
         ask_cnt_ff   <= ask_cnt_in;
         bid_head_ff  <= bid_head_in;
         ask_head_ff  <= ask_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tbl_ff        <= tbl_in;
      limit_ff      <= limit_in;
      price_ff      <= price_in;
      qty_ff        <= qty_in;
      rem_ff        <= rem_in;
      total_ff      <= total_in;
      ident_ff      <= ident_in;
      ts_ff         <= ts_in;
      st_ff         <= st_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      rsp_summ_ff   <= rsp_summ_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                  = (state_ff != plob_pkg::ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_is_summary        = rsp_summ_ff;
   assign rsp_trade_price_cents = rsp_price_ff;
   assign rsp_trade_quantity    = rsp_qty_ff;
   assign rsp_taker_ident       = ident_ff;
   assign rsp_trade_time        = ts_ff;
   assign rsp_total_traded      = rsp_total_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_last              = rsp_summ_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (bid_cnt_ff <= LV_C) && (ask_cnt_ff <= LV_C))
      else $error("level count above table size");

   a_shift_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plob_pkg::ST_SHIFT) |-> (cur_cnt < LV_C) && (j_ff > i_ff))
      else $error("shift into a full table");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted without going busy");

   a_summary_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_summary) |=> !rsp_valid)
      else $error("result right after a summary");
`endif

endmodule
